FILE: design/pffc_pkg.sv
package pffc_pkg;

    localparam int PFFC_PLANE_BYTES   = 65536;
    localparam int PFFC_MAX_SCANLINES = 256;

    // widest address sum: offset + y * stride + x / 4
    localparam int SUM_W = 19;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_FILL  = 2'd1,
        REQ_COPY  = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    localparam logic [1:0] CFG_BUFFER_OFFSET = 2'd0;
    localparam logic [1:0] CFG_LINE_WIDTH    = 2'd1;

    localparam logic [9:0] LINE_WIDTH_RST = 10'd80;

    localparam logic [3:0] LEFT_EDGE  [4] = '{4'hF, 4'hE, 4'hC, 4'h8};
    localparam logic [3:0] RIGHT_EDGE [4] = '{4'h1, 4'h3, 4'h7, 4'hF};

    typedef struct packed {
        t_req        req_type;
        logic [3:0]  plane_mask;
        logic [15:0] address;
        logic [15:0] src_address;
        logic [11:0] pos_x;
        logic [7:0]  pos_y;
        logic [11:0] span_width;
        logic [9:0]  span_height;
        logic [7:0]  color;
        logic [1:0]  read_plane;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        t_req       done_type;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] value;
    } t_wrap_req;

    typedef struct packed {
        logic        we;
        logic [3:0]  mask;
        logic [31:0] data;
    } t_ram_wr;

endpackage

FILE: design/pffc_ram.sv
module pffc_ram
    import pffc_pkg::*;
#(
    parameter int DEPTH = PFFC_PLANE_BYTES,
    parameter int AW    = $clog2(PFFC_PLANE_BYTES)
) (
    input  logic          i_clk,
    input  t_ram_wr       i_wr,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            for (int n = 0; n < 4; n++) begin
                if (i_wr.mask[n]) begin
                    mem[i_waddr][8*n +: 8] <= i_wr.data[8*n +: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pffc_wrap.sv
module pffc_wrap
    import pffc_pkg::*;
#(
    parameter int PLANE_BYTES = PFFC_PLANE_BYTES,
    parameter int AW          = $clog2(PFFC_PLANE_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_wrap_req     i_req,
    output logic          o_done,
    output logic [AW-1:0] o_result
);

    // restoring reduction, one shifted-modulus compare/subtract per cycle
    localparam int K0  = SUM_W - AW;
    localparam int KW  = (K0 > 0) ? $clog2(K0 + 1) : 1;
    localparam int VW1 = SUM_W + 1;
    localparam int VW2 = SUM_W + 2;
    localparam logic [SUM_W:0] MODW = VW1'(PLANE_BYTES);

    logic [SUM_W-1:0] r_val, n_val;
    logic [KW-1:0]    r_k;
    logic             r_run;
    logic             r_done;
    logic [SUM_W:0]   shifted;
    logic [SUM_W+1:0] diff;

    always_comb begin
        shifted = MODW << r_k;
        diff    = VW2'(r_val) - VW2'(shifted);
        n_val   = diff[SUM_W+1] ? r_val : diff[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
            r_val  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_val <= i_req.value;
                r_k   <= KW'(K0);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_val <= n_val;
                if (r_k == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - KW'(1);
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_val[AW-1:0];

endmodule

FILE: design/planar_frame_fill_copy_engine.sv
// channel   direction  handshake                       payload
// command   in         start & !busy                   i_cmd (t_cmd)
// result    out        o_strobe, one cycle, no stall   o_result (t_result)
// config    in         i_cfg_valid & o_cfg_ready       i_cfg_index, i_cfg_data
//
// Address wrap runs on one shared compare/subtract unit: a load, then
// K+1 compare steps, K = 19 - clog2(PLANE_BYTES) (K = 3 at 64K).
// Write and read wrap one address, fill forms its row base first, and copy wraps
// source then destination and alternates read and write (one frame store port pair).
// Empty fill/copy: strobe on the next cycle, engine stays free. Reset is synchronous;
// frame store is not cleared. Results cannot be stalled; the next command may start
// on the strobe cycle.
module planar_frame_fill_copy_engine
    import pffc_pkg::*;
#(
    parameter int PLANE_BYTES   = PFFC_PLANE_BYTES,
    parameter int MAX_SCANLINES = PFFC_MAX_SCANLINES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_strobe,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW  = $clog2(PLANE_BYTES);
    localparam int AW1 = AW + 1;
    localparam logic [AW:0] MODA = AW1'(PLANE_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_BASE, S_RED_A, S_RED_B, S_WR, S_RD, S_RD_DATA,
        S_FILL, S_CP_RD, S_CP_WR
    } t_state;

    t_state        r_state;
    t_cmd          r_cmd;
    logic [15:0]   r_buffer_offset;
    logic [9:0]    r_line_width;
    logic          r_strobe;
    t_result       r_out;
    t_wrap_req     r_red;
    logic [17:0]   r_prod;
    logic [AW-1:0] r_ptr, r_row_base;
    logic [AW-1:0] r_src_ptr, r_src_base, r_dst_ptr, r_dst_base;
    logic [11:0]   r_col, r_col_last;
    logic [9:0]    r_rows;
    logic [3:0]    r_lmask, r_rmask;

    logic          red_done;
    logic [AW-1:0] red_res;
    t_ram_wr       ram_wr;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_rdata;
    logic [3:0]    fill_mask;

    logic [12:0]   fx_end;
    logic [10:0]   nb_m1;
    logic          fill_empty, copy_empty;

    function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a,
                                               input logic [9:0] b);
        logic [AW:0] s;
        s = AW1'(a) + AW1'(b);
        if (s >= MODA) begin
            s = s - MODA;
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        fx_end     = 13'(i_cmd.pos_x) + 13'(i_cmd.span_width) - 13'd1;
        nb_m1      = fx_end[12:2] - 11'(i_cmd.pos_x[11:2]);
        fill_empty = (i_cmd.span_width == '0) || (i_cmd.span_height == '0)
                     || (int'(i_cmd.pos_y) >= MAX_SCANLINES);
        copy_empty = (i_cmd.span_width == '0) || (i_cmd.span_height == '0);
    end

    always_comb begin
        fill_mask = ((r_col == '0) ? r_lmask : 4'hF)
                  & ((r_col == r_col_last) ? r_rmask : 4'hF);
        ram_wr.we   = (r_state == S_WR) || (r_state == S_FILL) || (r_state == S_CP_WR);
        ram_wr.mask = (r_state == S_WR)   ? r_cmd.plane_mask :
                      (r_state == S_FILL) ? fill_mask : 4'hF;
        ram_wr.data = (r_state == S_CP_WR) ? ram_rdata : {4{r_cmd.color}};
        ram_waddr   = (r_state == S_CP_WR) ? r_dst_ptr : r_ptr;
        ram_raddr   = (r_state == S_CP_RD) ? r_src_ptr : r_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_offset <= '0;
            r_line_width    <= LINE_WIDTH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BUFFER_OFFSET: r_buffer_offset <= i_cfg_data;
                CFG_LINE_WIDTH:    r_line_width    <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_strobe  <= 1'b0;
            r_red     <= '0;
            r_out     <= '0;
        end else begin
            r_strobe    <= 1'b0;
            r_red.start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd      <= i_cmd;
                        r_lmask    <= LEFT_EDGE[i_cmd.pos_x[1:0]];
                        r_rmask    <= RIGHT_EDGE[fx_end[1:0]];
                        r_col_last <= (i_cmd.req_type == REQ_FILL) ? 12'(nb_m1)
                                                                   : i_cmd.span_width - 12'd1;
                        unique case (i_cmd.req_type)
                            REQ_WRITE, REQ_READ: begin
                                r_red.start <= 1'b1;
                                r_red.value <= SUM_W'(i_cmd.address);
                                r_state     <= S_RED_A;
                            end
                            REQ_FILL: begin
                                if (fill_empty) begin
                                    r_strobe        <= 1'b1;
                                    r_out.read_data <= '0;
                                    r_out.done_type <= REQ_FILL;
                                end else begin
                                    r_state <= S_MUL;
                                end
                            end
                            REQ_COPY: begin
                                if (copy_empty) begin
                                    r_strobe        <= 1'b1;
                                    r_out.read_data <= '0;
                                    r_out.done_type <= REQ_COPY;
                                end else begin
                                    r_red.start <= 1'b1;
                                    r_red.value <= SUM_W'(i_cmd.src_address);
                                    r_state     <= S_RED_A;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= 18'(r_cmd.pos_y) * 18'(r_line_width);
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    r_red.start <= 1'b1;
                    r_red.value <= SUM_W'(r_buffer_offset) + SUM_W'(r_prod)
                                   + SUM_W'(r_cmd.pos_x[11:2]);
                    r_state     <= S_RED_A;
                end
                S_RED_A: begin
                    if (red_done) begin
                        r_ptr      <= red_res;
                        r_row_base <= red_res;
                        r_src_ptr  <= red_res;
                        r_src_base <= red_res;
                        r_col      <= '0;
                        r_rows     <= r_cmd.span_height;
                        unique case (r_cmd.req_type)
                            REQ_WRITE: r_state <= S_WR;
                            REQ_READ:  r_state <= S_RD;
                            REQ_FILL:  r_state <= S_FILL;
                            REQ_COPY: begin
                                r_red.start <= 1'b1;
                                r_red.value <= SUM_W'(r_cmd.address);
                                r_state     <= S_RED_B;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RED_B: begin
                    if (red_done) begin
                        r_dst_ptr  <= red_res;
                        r_dst_base <= red_res;
                        r_state    <= S_CP_RD;
                    end
                end
                S_WR: begin
                    r_strobe        <= 1'b1;
                    r_out.read_data <= '0;
                    r_out.done_type <= REQ_WRITE;
                    r_state         <= S_IDLE;
                end
                S_RD: begin
                    r_state <= S_RD_DATA;
                end
                S_RD_DATA: begin
                    r_strobe        <= 1'b1;
                    r_out.read_data <= ram_rdata[8*r_cmd.read_plane +: 8];
                    r_out.done_type <= REQ_READ;
                    r_state         <= S_IDLE;
                end
                S_FILL: begin
                    if (r_col == r_col_last) begin
                        if (r_rows == 10'd1) begin
                            r_strobe        <= 1'b1;
                            r_out.read_data <= '0;
                            r_out.done_type <= REQ_FILL;
                            r_state         <= S_IDLE;
                        end else begin
                            r_row_base <= add_wrap(r_row_base, r_line_width);
                            r_ptr      <= add_wrap(r_row_base, r_line_width);
                            r_col      <= '0;
                            r_rows     <= r_rows - 10'd1;
                        end
                    end else begin
                        r_ptr <= add_wrap(r_ptr, 10'd1);
                        r_col <= r_col + 12'd1;
                    end
                end
                S_CP_RD: begin
                    r_state <= S_CP_WR;
                end
                S_CP_WR: begin
                    r_state <= S_CP_RD;
                    if (r_col == r_col_last) begin
                        if (r_rows == 10'd1) begin
                            r_strobe        <= 1'b1;
                            r_out.read_data <= '0;
                            r_out.done_type <= REQ_COPY;
                            r_state         <= S_IDLE;
                        end else begin
                            r_src_base <= add_wrap(r_src_base, r_line_width);
                            r_src_ptr  <= add_wrap(r_src_base, r_line_width);
                            r_dst_base <= add_wrap(r_dst_base, r_line_width);
                            r_dst_ptr  <= add_wrap(r_dst_base, r_line_width);
                            r_col      <= '0;
                            r_rows     <= r_rows - 10'd1;
                        end
                    end else begin
                        r_src_ptr <= add_wrap(r_src_ptr, 10'd1);
                        r_dst_ptr <= add_wrap(r_dst_ptr, 10'd1);
                        r_col     <= r_col + 12'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    pffc_wrap #(
        .PLANE_BYTES (PLANE_BYTES),
        .AW          (AW)
    ) u_wrap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (r_red),
        .o_done   (red_done),
        .o_result (red_res)
    );

    pffc_ram #(
        .DEPTH (PLANE_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_waddr (ram_waddr),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.req_type != REQ_FILL && i_cmd.req_type != REQ_COPY)
        |=> busy)
        else $error("command accepted but engine not busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while engine busy");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !ram_wr.we)
        else $error("frame store written while idle");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.done_type != REQ_READ) |-> (o_result.read_data == '0))
        else $error("nonzero data on non-read result");

endmodule
